[sv/indexed_linked_list_with_free_list_defines.svh]
// Assertion macros for the indexed linked list block.
`ifndef INDEXED_LINKED_LIST_WITH_FREE_LIST_DEFINES_SVH
`define INDEXED_LINKED_LIST_WITH_FREE_LIST_DEFINES_SVH

// Clocked assertion, suspended while reset is high.
`define ILIST_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ILIST_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ilist_pkg.sv]
// Shared codes and sizes for the indexed linked list block.
`timescale 1ns / 1ps

package ilist_pkg;

   localparam int MaxResults = 64;
   localparam int CountWidth = $clog2(MaxResults);

   typedef enum logic [2:0] {
      OpInsert = 3'd0,
      OpAppend = 3'd1,
      OpDelete = 3'd2,
      OpPrint  = 3'd3,
      OpClear  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      StatusOk    = 2'd0,
      StatusFull  = 2'd1,
      StatusEmpty = 2'd2
   } status_type;

endpackage

[sv/indexed_linked_list_with_free_list.sv]
// Top level: singly linked record list in a node memory, with a free list.
// An operation word is taken when start is high and busy is low; busy drops in
// the cycle its last response word is on the rsp_ ports. Responses appear on the rsp_
// ports for one cycle with rsp_strobe, in the cycle after they are computed, and
// cannot be held off. Insert works at the head and delete removes the head.
// Append walks the node memory one record per cycle to the tail. Print issues
// one record per cycle, at most 64; clear frees one head per cycle. The rate is
// set by the single read port of the node memory, whose read data is registered
// and arrives in the cycle after the address. A full store returns status full
// and leaves the list untouched; delete or print of an empty list returns
// status empty. No clearing pass after reset.
`timescale 1ns / 1ps
`include "indexed_linked_list_with_free_list_defines.svh"

module indexed_linked_list_with_free_list #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_record_number,
   input  logic [63:0]        req_name_low,
   input  logic [15:0]        req_name_high,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_entry_valid,
   output logic signed [31:0] rsp_out_number,
   output logic [63:0]        rsp_out_name_low,
   output logic [15:0]        rsp_out_name_high,
   output logic               rsp_last
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] NilLink = '1;

   typedef struct packed {
      logic [LW-1:0] next;
      logic [31:0]   number;
      logic [63:0]   name_low;
      logic [15:0]   name_high;
   } node_type;

   typedef enum logic [2:0] {
      StIdle,
      StInsert,
      StWalk,
      StFill,
      StDelete,
      StPrint,
      StClear,
      StOther
   } state_type;

   node_type      node_mem [CAPACITY];
   logic [LW-1:0] free_mem [CAPACITY];

   state_type     state_ff, state_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] used_ff, used_in;
   logic [LW-1:0] p_ff, p_in;
   logic [IW-1:0] alloc_ff, alloc_in;
   logic [ilist_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic [31:0]   number_ff, number_in;
   logic [63:0]   name_low_ff, name_low_in;
   logic [15:0]   name_high_ff, name_high_in;

   logic          strobe_ff, strobe_in;
   ilist_pkg::status_type status_ff, status_in;
   logic          entry_ff, entry_in;
   logic [31:0]   onum_ff, onum_in;
   logic [63:0]   olow_ff, olow_in;
   logic [15:0]   ohigh_ff, ohigh_in;
   logic          last_ff, last_in;

   node_type      node_rd_ff;
   logic [LW-1:0] free_rd_ff;

   logic          node_we;
   logic [IW-1:0] node_wa;
   node_type      node_wd;
   logic [IW-1:0] node_ra;
   logic          free_we;
   logic [IW-1:0] free_wa;
   logic [LW-1:0] free_wd;

   logic          from_free;
   logic          full;
   logic [IW-1:0] alloc_idx;

   assign from_free = !free_head_ff[IW];
   assign full      = !from_free && (used_ff == LW'(CAPACITY));
   assign alloc_idx = from_free ? free_head_ff[IW-1:0] : used_ff[IW-1:0];

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      free_head_in = free_head_ff;
      used_in      = used_ff;
      p_in         = p_ff;
      alloc_in     = alloc_ff;
      cnt_in       = cnt_ff;
      number_in    = number_ff;
      name_low_in  = name_low_ff;
      name_high_in = name_high_ff;
      strobe_in    = 1'b0;
      status_in    = ilist_pkg::StatusOk;
      entry_in     = 1'b0;
      onum_in      = '0;
      olow_in      = '0;
      ohigh_in     = '0;
      last_in      = 1'b1;
      node_we      = 1'b0;
      node_wa      = alloc_idx;
      node_wd      = '{next: head_ff, number: number_ff, name_low: name_low_ff,
                       name_high: name_high_ff};
      node_ra      = head_ff[IW-1:0];
      free_we      = 1'b0;
      free_wa      = head_ff[IW-1:0];
      free_wd      = free_head_ff;

      unique case (state_ff)
         StIdle: begin
            if (start) begin
               p_in         = head_ff;
               cnt_in       = '0;
               number_in    = req_record_number;
               name_low_in  = req_name_low;
               name_high_in = req_name_high;
               unique case (ilist_pkg::op_type'(req_operation))
                  ilist_pkg::OpInsert: state_in = StInsert;
                  ilist_pkg::OpAppend: state_in = head_ff[IW] ? StInsert : StWalk;
                  ilist_pkg::OpDelete: state_in = StDelete;
                  ilist_pkg::OpPrint:  state_in = StPrint;
                  ilist_pkg::OpClear:  state_in = StClear;
                  default:             state_in = StOther;
               endcase
            end
         end
         StInsert: begin
            strobe_in = 1'b1;
            state_in  = StIdle;
            if (full) begin
               status_in = ilist_pkg::StatusFull;
            end else begin
               node_we = 1'b1;
               head_in = {1'b0, alloc_idx};
               if (from_free) free_head_in = free_rd_ff;
               else used_in = used_ff + LW'(1);
            end
         end
         StWalk: begin
            if (!node_rd_ff.next[IW]) begin
               p_in    = node_rd_ff.next;
               node_ra = node_rd_ff.next[IW-1:0];
            end else if (full) begin
               strobe_in = 1'b1;
               status_in = ilist_pkg::StatusFull;
               state_in  = StIdle;
            end else begin
               node_we      = 1'b1;
               node_wa      = p_ff[IW-1:0];
               node_wd      = node_rd_ff;
               node_wd.next = {1'b0, alloc_idx};
               alloc_in     = alloc_idx;
               if (from_free) free_head_in = free_rd_ff;
               else used_in = used_ff + LW'(1);
               state_in     = StFill;
            end
         end
         StFill: begin
            node_we      = 1'b1;
            node_wa      = alloc_ff;
            node_wd.next = NilLink;
            strobe_in    = 1'b1;
            state_in     = StIdle;
         end
         StDelete: begin
            strobe_in = 1'b1;
            state_in  = StIdle;
            if (head_ff[IW]) begin
               status_in = ilist_pkg::StatusEmpty;
            end else begin
               head_in      = node_rd_ff.next;
               free_we      = 1'b1;
               free_head_in = head_ff;
            end
         end
         StPrint: begin
            strobe_in = 1'b1;
            if (head_ff[IW]) begin
               status_in = ilist_pkg::StatusEmpty;
               state_in  = StIdle;
            end else begin
               entry_in = 1'b1;
               onum_in  = node_rd_ff.number;
               olow_in  = node_rd_ff.name_low;
               ohigh_in = node_rd_ff.name_high;
               last_in  = node_rd_ff.next[IW] ||
                          (cnt_ff == ilist_pkg::CountWidth'(ilist_pkg::MaxResults - 1));
               if (last_in) begin
                  state_in = StIdle;
               end else begin
                  cnt_in  = cnt_ff + ilist_pkg::CountWidth'(1);
                  node_ra = node_rd_ff.next[IW-1:0];
               end
            end
         end
         StClear: begin
            if (head_ff[IW]) begin
               strobe_in = 1'b1;
               state_in  = StIdle;
            end else begin
               head_in      = node_rd_ff.next;
               free_we      = 1'b1;
               free_head_in = head_ff;
               node_ra      = node_rd_ff.next[IW-1:0];
            end
         end
         StOther: begin
            strobe_in = 1'b1;
            state_in  = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         head_ff      <= NilLink;
         free_head_ff <= NilLink;
         used_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_head_ff <= free_head_in;
         used_ff      <= used_in;
         strobe_ff    <= strobe_in;
      end
      p_ff         <= p_in;
      alloc_ff     <= alloc_in;
      cnt_ff       <= cnt_in;
      number_ff    <= number_in;
      name_low_ff  <= name_low_in;
      name_high_ff <= name_high_in;
      status_ff    <= status_in;
      entry_ff     <= entry_in;
      onum_ff      <= onum_in;
      olow_ff      <= olow_in;
      ohigh_ff     <= ohigh_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_wa] <= node_wd;
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (free_we) free_mem[free_wa] <= free_wd;
      free_rd_ff <= free_mem[free_head_ff[IW-1:0]];
   end

   assign busy              = (state_ff != StIdle);
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_valid   = entry_ff;
   assign rsp_out_number    = $signed(onum_ff);
   assign rsp_out_name_low  = olow_ff;
   assign rsp_out_name_high = ohigh_ff;
   assign rsp_last          = last_ff;

   `ILIST_ASSERT_RST(a_rsp_after_busy, clock, reset, rsp_strobe |-> $past(busy), "word without work")
   `ILIST_ASSERT_RST(a_more_words_busy, clock, reset, (rsp_strobe && !rsp_last) |-> busy, "early idle")
   `ILIST_ASSERT_RST(a_entry_ok, clock, reset, rsp_entry_valid |-> (rsp_status == ilist_pkg::StatusOk), "bad entry status")
   `ILIST_ASSERT(a_used_bound, clock, reset || (used_ff <= LW'(CAPACITY)), "high water overrun")

endmodule
